// ----- hw/rtl/tbom_pkg.sv -----
// Shared types and codes for the triple-buffer ownership manager.
package tbom_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned NumBufs = 3;

  localparam logic [1:0] PROD_WAITING = 2'd0;

  typedef enum logic [2:0] {
    KIND_START      = 3'd0,
    KIND_FILL_DONE  = 3'd1,
    KIND_ACQUIRE    = 3'd2,
    KIND_RELEASE    = 3'd3,
    KIND_RESUME     = 3'd4,
    KIND_READ_COUNT = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    BUF_FREE    = 2'd0,
    BUF_FILLING = 2'd1,
    BUF_READY   = 2'd2,
    BUF_IN_USE  = 2'd3
  } buf_st_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_BUSY = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic        buffer_valid;
    logic [1:0]  buffer_index;
    logic        error;
    logic [1:0]  producer_state;
    logic [31:0] pause_gap;
    logic [31:0] paused_count;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/tbom_ctrl.sv -----
// Controller state machine: sequences item capture and commit.
module tbom_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbom_pkg::dp_sts_t  sts_i,
  output tbom_pkg::ctrl_cmd_t cmd_o
);

  tbom_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbom_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tbom_pkg::CTRL_IDLE: begin
        if (in_valid_i) begin
          state_d = tbom_pkg::CTRL_BUSY;
        end
      end
      tbom_pkg::CTRL_BUSY: begin
        if (sts_i.out_free) begin
          state_d = tbom_pkg::CTRL_IDLE;
        end
      end
      default: state_d = tbom_pkg::CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      tbom_pkg::CTRL_IDLE: begin
        cmd_o.load_in = in_valid_i;
      end
      tbom_pkg::CTRL_BUSY: begin
        in_stall_o   = 1'b1;
        cmd_o.commit = sts_i.out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

// ----- hw/rtl/tbom_dp.sv -----
// Datapath: buffer status, producer mode, pause counter, stop time and result register.
module tbom_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbom_pkg::in_item_t   in_item_i,
  input  tbom_pkg::ctrl_cmd_t  cmd_i,
  output tbom_pkg::dp_sts_t    sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tbom_pkg::out_item_t  out_item_o
);

  tbom_pkg::in_item_t  item_q;
  tbom_pkg::out_item_t out_q, res;
  logic                out_valid_q;

  tbom_pkg::buf_st_e   status_q [tbom_pkg::NumBufs];
  tbom_pkg::buf_st_e   status_d [tbom_pkg::NumBufs];
  logic [1:0]          mode_q, mode_d;
  logic [31:0]         pause_q, pause_d;
  logic [tbom_pkg::TimeW-1:0] stop_q, stop_d;

  logic       ready_hit, inuse_hit, free_hit;
  logic [1:0] ready_idx, inuse_idx, free_idx;
  logic [1:0] cur, nxt;
  logic       nxt_free;
  logic [tbom_pkg::TimeW-1:0] gap;

  // Lowest-numbered buffer in each status; scanning downward lets the lowest win.
  always_comb begin
    ready_hit = 1'b0;
    inuse_hit = 1'b0;
    free_hit  = 1'b0;
    ready_idx = 2'd0;
    inuse_idx = 2'd0;
    free_idx  = 2'd0;
    for (int i = tbom_pkg::NumBufs - 1; i >= 0; i--) begin
      if (status_q[i] == tbom_pkg::BUF_READY) begin
        ready_hit = 1'b1;
        ready_idx = 2'(i);
      end
      if (status_q[i] == tbom_pkg::BUF_IN_USE) begin
        inuse_hit = 1'b1;
        inuse_idx = 2'(i);
      end
      if (status_q[i] == tbom_pkg::BUF_FREE) begin
        free_hit = 1'b1;
        free_idx = 2'(i);
      end
    end
  end

  always_comb begin
    cur      = mode_q - 2'd1;
    nxt      = (cur == 2'd2) ? 2'd0 : cur + 2'd1;
    nxt_free = 1'b0;
    for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
      if (2'(i) == nxt && status_q[i] == tbom_pkg::BUF_FREE) begin
        nxt_free = 1'b1;
      end
    end
    gap = tbom_pkg::TimeW'(item_q.timestamp) - stop_q;
  end

  always_comb begin
    for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
      status_d[i] = status_q[i];
    end
    mode_d  = mode_q;
    pause_d = pause_q;
    stop_d  = stop_q;
    res     = '0;
    case (item_q.kind)
      tbom_pkg::KIND_START: begin
        status_d[0] = tbom_pkg::BUF_FILLING;
        status_d[1] = tbom_pkg::BUF_FREE;
        status_d[2] = tbom_pkg::BUF_FREE;
        mode_d      = 2'd1;
      end
      tbom_pkg::KIND_FILL_DONE: begin
        if (mode_q == tbom_pkg::PROD_WAITING) begin
          res.error = 1'b1;
        end else begin
          stop_d = tbom_pkg::TimeW'(item_q.timestamp);
          for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
            if (2'(i) == cur) begin
              status_d[i] = tbom_pkg::BUF_READY;
            end
            if (2'(i) == nxt && nxt_free) begin
              status_d[i] = tbom_pkg::BUF_FILLING;
            end
          end
          if (nxt_free) begin
            mode_d = nxt + 2'd1;
          end else begin
            mode_d  = tbom_pkg::PROD_WAITING;
            pause_d = pause_q + 32'd1;
          end
        end
      end
      tbom_pkg::KIND_ACQUIRE: begin
        if (ready_hit) begin
          for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
            if (2'(i) == ready_idx) begin
              status_d[i] = tbom_pkg::BUF_IN_USE;
            end
          end
          res.buffer_valid = 1'b1;
          res.buffer_index = ready_idx;
        end
      end
      tbom_pkg::KIND_RELEASE: begin
        if (inuse_hit) begin
          for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
            if (2'(i) == inuse_idx) begin
              status_d[i] = tbom_pkg::BUF_FREE;
            end
          end
        end else begin
          res.error = 1'b1;
        end
      end
      tbom_pkg::KIND_RESUME: begin
        if (mode_q == tbom_pkg::PROD_WAITING && free_hit) begin
          for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
            if (2'(i) == free_idx) begin
              status_d[i] = tbom_pkg::BUF_FILLING;
            end
          end
          mode_d           = free_idx + 2'd1;
          res.buffer_valid = 1'b1;
          res.buffer_index = free_idx;
          res.pause_gap    = 32'(gap);
        end
      end
      tbom_pkg::KIND_READ_COUNT: begin
        res.paused_count = pause_q;
        pause_d          = 32'd0;
      end
      default: ;
    endcase
    res.producer_state = mode_d;
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      item_q <= in_item_i;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
        status_q[i] <= tbom_pkg::BUF_FREE;
      end
      mode_q      <= tbom_pkg::PROD_WAITING;
      pause_q     <= '0;
      stop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        for (int i = 0; i < tbom_pkg::NumBufs; i++) begin
          status_q[i] <= status_d[i];
        end
        mode_q      <= mode_d;
        pause_q     <= pause_d;
        stop_q      <= stop_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/triple_buffer_ownership_manager.sv -----
// Triple-buffer ownership manager: one event in, one result out, per transfer.
// Each event is first captured from the transfer into the item register; the
// commit then applies the event to the three buffer status registers, producer
// mode, pause counter and stop time and loads the result register. A new event
// can be taken while the previous result still waits in the result register,
// but not before the previous event has been committed.
// The commit cycle waits only when the result register is held by a stall.
module triple_buffer_ownership_manager (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbom_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tbom_pkg::out_item_t out_item_o
);

  tbom_pkg::ctrl_cmd_t cmd;
  tbom_pkg::dp_sts_t   sts;

  tbom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbom_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // An accepted event is always worked on before the next one is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer accepted while an event is in flight");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.buffer_index != 2'd3)
    else $error("buffer index out of range");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.buffer_valid |-> out_item_o.buffer_index == 2'd0)
    else $error("buffer index set without a buffer");

  // A gap is reported only by a resume that found a buffer.
  a_gap_needs_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pause_gap != 32'd0 |->
      out_item_o.buffer_valid && !out_item_o.error)
    else $error("pause gap without a resumed buffer");
`endif

endmodule
